// ===== hdl/ps2_scancode_decoder_core_defines.svh =====
// ============================================================================
// PS/2 decoder assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ============================================================================
`ifndef PS2_SCANCODE_DECODER_CORE_DEFINES_SVH
`define PS2_SCANCODE_DECODER_CORE_DEFINES_SVH

// Implication in the same cycle.
`define PS2SD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define PS2SD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ps2sd_pkg.sv =====
// ============================================================================
// ps2sd_pkg
// Types, constants and lookup functions of the set-1 scancode decoder.
// ============================================================================
package ps2sd_pkg;

   localparam int ByteW  = 8;
   localparam int KeyW   = 7;
   localparam int ModW   = 7;
   localparam int StateW = ModW + 1;

   localparam logic [ByteW-1:0] PrefixByte = 8'hE0;

   // modifier bit positions
   localparam int ModShift  = 0;
   localparam int ModAlt    = 1;
   localparam int ModCtrl   = 2;
   localparam int ModWin    = 3;
   localparam int ModCaps   = 4;
   localparam int ModScroll = 5;
   localparam int ModNum    = 6;

   // key codes with modifier meaning
   localparam logic [KeyW-1:0] KeyLCtrl  = 7'h1d;
   localparam logic [KeyW-1:0] KeyLShift = 7'h2a;
   localparam logic [KeyW-1:0] KeyRShift = 7'h36;
   localparam logic [KeyW-1:0] KeyLAlt   = 7'h38;
   localparam logic [KeyW-1:0] KeyCaps   = 7'h3a;
   localparam logic [KeyW-1:0] KeyNum    = 7'h45;
   localparam logic [KeyW-1:0] KeyScroll = 7'h46;
   localparam logic [KeyW-1:0] KeyLastDirect = 7'h53;
   localparam logic [KeyW-1:0] KeyF11    = 7'h57;
   localparam logic [KeyW-1:0] KeyF12    = 7'h58;

   typedef struct packed {
      logic             esc;
      logic [ModW-1:0]  mods;
   } state_type;

   typedef struct packed {
      logic [ByteW-1:0] key_code;
      logic             is_release;
      logic [ModW-1:0]  mods;
   } result_type;

   function automatic logic [ModW-1:0] held_bits(input logic [KeyW-1:0] k);
      logic [ModW-1:0] r;
      r = '0;
      case (k)
         KeyLCtrl:             r[ModCtrl]  = 1'b1;
         KeyLShift, KeyRShift: r[ModShift] = 1'b1;
         KeyLAlt:              r[ModAlt]   = 1'b1;
         default:              r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [ModW-1:0] lock_bits(input logic [KeyW-1:0] k);
      logic [ModW-1:0] r;
      r = '0;
      case (k)
         KeyCaps:   r[ModCaps]   = 1'b1;
         KeyNum:    r[ModNum]    = 1'b1;
         KeyScroll: r[ModScroll] = 1'b1;
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [ByteW-1:0] plain_key(input logic [KeyW-1:0] k);
      logic [ByteW-1:0] r;
      if (k <= KeyLastDirect) begin
         r = {1'b0, k};
      end else if (k == KeyF11) begin
         r = 8'd84;
      end else if (k == KeyF12) begin
         r = 8'd85;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic logic [ByteW-1:0] escaped_key(input logic [KeyW-1:0] k);
      logic [ByteW-1:0] r;
      case (k)
         7'h1c:   r = 8'd86;   // keypad enter
         7'h1d:   r = 8'd87;   // right ctrl
         7'h35:   r = 8'd88;   // keypad divide
         7'h38:   r = 8'd89;   // right alt
         7'h47:   r = 8'd90;   // home
         7'h48:   r = 8'd91;   // up
         7'h49:   r = 8'd92;   // page up
         7'h4b:   r = 8'd93;   // left
         7'h4d:   r = 8'd94;   // right
         7'h4f:   r = 8'd95;   // end
         7'h50:   r = 8'd96;   // down
         7'h51:   r = 8'd97;   // page down
         7'h52:   r = 8'd98;   // insert
         7'h53:   r = 8'd99;   // delete
         7'h5b:   r = 8'd100;  // left windows
         7'h5c:   r = 8'd101;  // right windows
         7'h5d:   r = 8'd102;  // menu
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/ps2sd_state_ram.sv =====
// ============================================================================
// ps2sd_state_ram
// Single-entry decoder state memory with registered read; reads zero until
// the first write after reset.
// ============================================================================
module ps2sd_state_ram (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  ps2sd_pkg::state_type  wr_data,
   output ps2sd_pkg::state_type  rd_data
);
   import ps2sd_pkg::*;

   localparam int Depth = 1;

   state_type mem_ff [Depth];
   logic      written_ff;
   state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[0] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= 1'b0;
      end else if (wr_en) begin
         written_ff <= 1'b1;
      end
   end

   // read every cycle, old data on a same-cycle write
   always_ff @(posedge clock) begin
      rd_data_ff <= written_ff ? mem_ff[0] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ps2sd_update.sv =====
// ============================================================================
// ps2sd_update
// Next-state and result computation for one scancode byte.
// ============================================================================
module ps2sd_update (
   input  logic [7:0]              scan_byte,
   input  ps2sd_pkg::state_type    cur_state,
   output ps2sd_pkg::state_type    nxt_state,
   output logic                    has_result,
   output ps2sd_pkg::result_type   result
);
   import ps2sd_pkg::*;

   logic [KeyW-1:0] key;
   logic            rel;
   logic            is_prefix;
   logic            is_fake_shift;
   logic [ModW-1:0] held;
   logic [ModW-1:0] mods_upd;

   assign key           = scan_byte[KeyW-1:0];
   assign rel           = scan_byte[ByteW-1];
   assign is_prefix     = (scan_byte == PrefixByte);
   assign held          = held_bits(key);
   assign is_fake_shift = cur_state.esc && (key == KeyLShift || key == KeyRShift);

   always_comb begin
      if (rel) begin
         mods_upd = cur_state.mods & ~held;
      end else begin
         mods_upd = (cur_state.mods | held) ^ lock_bits(key);
      end
   end

   always_comb begin
      has_result = 1'b0;
      nxt_state  = cur_state;
      if (is_prefix) begin
         nxt_state.esc = 1'b1;
      end else if (is_fake_shift) begin
         nxt_state.esc = 1'b0;
      end else begin
         has_result     = 1'b1;
         nxt_state.esc  = 1'b0;
         nxt_state.mods = mods_upd;
      end
   end

   assign result.key_code   = cur_state.esc ? escaped_key(key) : plain_key(key);
   assign result.is_release = rel;
   assign result.mods       = mods_upd;

endmodule

// ===== hdl/ps2sd_out_buf.sv =====
// ============================================================================
// ps2sd_out_buf
// Output register with a skid entry; takes a transaction while the held
// result waits.
// ============================================================================
module ps2sd_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ps2sd_pkg::result_type  push_data,
   output logic                   can_push,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ps2sd_pkg::result_type  out_data
);
   import ps2sd_pkg::*;

   logic       out_vld_ff;
   logic       skid_vld_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       pop;

   assign pop      = out_vld_ff && out_ready;
   assign can_push = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff  <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   // payload: drain skid first, else load fresh data
   always_ff @(posedge clock) begin
      if (pop || !out_vld_ff) begin
         if (skid_vld_ff) begin
            out_ff <= skid_ff;
         end else if (push) begin
            out_ff <= push_data;
         end
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

endmodule

// ===== hdl/ps2_scancode_decoder_core.sv =====
// ============================================================================
// ps2_scancode_decoder_core
// Set-1 keyboard scancode decoder with held and lock modifier tracking.
// ============================================================================
// Usage:
//   req_* channel takes one raw set-1 scancode byte per transaction.
//   rsp_* channel gives one decoded key transaction per byte, except for
//   the 0xE0 escape prefix and escaped fake-shift codes, which only update
//   the escape state and give nothing.
//   Path: an accepted byte is registered in the decode stage, then in the
//   output register or its skid entry, before it shows up on rsp_*.
//   Throughput: one byte per cycle while the decode stage does not stall.
//   The rate is set by the read-modify-write of the single-entry state
//   memory: its read is registered, and the write of the previous byte is
//   forwarded to the next byte in the following cycle.
//   Reset: escape flag and all modifiers and locks read as zero; no
//   clearing pass is needed, the first write marks the entry valid.
//   Stall: with rsp_ready low, one more result fits in the skid entry; then
//   the decode stage holds and req_ready drops. Bytes that give no result
//   still move through while the output is stalled.
// ============================================================================
`include "ps2_scancode_decoder_core_defines.svh"

module ps2_scancode_decoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_scan_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_key_code,
   output logic       rsp_is_release,
   output logic       rsp_shift_held,
   output logic       rsp_alt_held,
   output logic       rsp_ctrl_held,
   output logic       rsp_win_held,
   output logic       rsp_caps_on,
   output logic       rsp_scroll_on,
   output logic       rsp_num_on
);
   import ps2sd_pkg::*;

   // decode stage
   logic             dec_vld_ff;
   logic [ByteW-1:0] dec_byte_ff;
   logic             dec_adv;

   // state memory and forwarding
   state_type  ram_rd;
   state_type  cur_state;
   state_type  nxt_state;
   logic       wr_en;
   logic       fwd_vld_ff;
   state_type  fwd_data_ff;

   logic       has_result;
   result_type result;
   result_type rsp_data;
   logic       buf_can_push;

   // advance when the byte gives nothing, or the buffer has room
   assign dec_adv   = dec_vld_ff && (!has_result || buf_can_push);
   assign req_ready = !dec_vld_ff || dec_adv;
   assign wr_en     = dec_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_vld_ff <= 1'b0;
      end else if (req_ready) begin
         dec_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         dec_byte_ff <= req_scan_byte;
      end
   end

   // bypass the write of the last edge, which the registered read missed
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else begin
         fwd_vld_ff <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_data_ff <= nxt_state;
      end
   end

   assign cur_state = fwd_vld_ff ? fwd_data_ff : ram_rd;

   ps2sd_state_ram u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (nxt_state),
      .rd_data (ram_rd)
   );

   ps2sd_update u_update (
      .scan_byte  (dec_byte_ff),
      .cur_state  (cur_state),
      .nxt_state  (nxt_state),
      .has_result (has_result),
      .result     (result)
   );

   ps2sd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (dec_adv && has_result),
      .push_data (result),
      .can_push  (buf_can_push),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_key_code   = rsp_data.key_code;
   assign rsp_is_release = rsp_data.is_release;
   assign rsp_shift_held = rsp_data.mods[ModShift];
   assign rsp_alt_held   = rsp_data.mods[ModAlt];
   assign rsp_ctrl_held  = rsp_data.mods[ModCtrl];
   assign rsp_win_held   = rsp_data.mods[ModWin];
   assign rsp_caps_on    = rsp_data.mods[ModCaps];
   assign rsp_scroll_on  = rsp_data.mods[ModScroll];
   assign rsp_num_on     = rsp_data.mods[ModNum];

   // the windows bit is never set by any key, through memory or bypass
   `PS2SD_ASSERT_NOW(a_win_never_set, dec_vld_ff, !cur_state.mods[ModWin], "win modifier set")
   // every delivered result leaves the escape flag cleared
   `PS2SD_ASSERT_NOW(a_result_clears_esc, wr_en && has_result, !nxt_state.esc, "esc kept after result")
   // a stalled decode stage holds its byte
   `PS2SD_ASSERT_NEXT(a_dec_hold, dec_vld_ff && !dec_adv, dec_vld_ff && $stable(dec_byte_ff), "decode byte lost on stall")
   // the bypass always carries the state written at the previous edge
   `PS2SD_ASSERT_NEXT(a_fwd_follows_write, wr_en, fwd_vld_ff && fwd_data_ff == $past(nxt_state), "bypass mismatch")

endmodule
